// ===== hw/rtl/grey_contrast_normalize_assert.svh =====
// assertion macros for the contrast stretch block
`ifndef GREY_CONTRAST_NORMALIZE_ASSERT_SVH
`define GREY_CONTRAST_NORMALIZE_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define GCN_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define GCN_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define GCN_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define GCN_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== hw/rtl/gcn_pkg.sv =====
package gcn_pkg;

    localparam int PIX_W    = 8;
    localparam int DIM_W    = 11;
    localparam int MAX_COLS = 1024;
    localparam int MAX_ROWS = 1024;
    localparam int LEN_W    = 21;
    localparam int CNT_W    = 21;

    localparam int NUM_W    = 17;
    localparam int DEN_W    = 9;
    localparam int DIV_STEPS = PIX_W;
    localparam int STEP_W   = $clog2(DIV_STEPS);

    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;

    localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;
    localparam logic [PIX_W-1:0] PIX_MIN = 8'd0;

    localparam logic [DIM_W-1:0] COLS_RESET = 11'd640;
    localparam logic [DIM_W-1:0] ROWS_RESET = 11'd480;

    // register index taken from paddr bit 2
    localparam logic REG_COLS = 1'b0;
    localparam logic REG_ROWS = 1'b1;

    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } div_req_t;

endpackage

// ===== hw/rtl/gcn_if.sv =====
interface gcn_pix_if;
    import gcn_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_in;

    modport source (output valid, output pixel_in, input ready);
    modport sink   (input valid, input pixel_in, output ready);
endinterface

interface gcn_res_if;
    import gcn_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_out;
    logic             last_pixel;

    modport source (output valid, output pixel_out, output last_pixel, input ready);
    modport sink   (input valid, input pixel_out, input last_pixel, output ready);
endinterface

// ===== hw/rtl/gcn_cfg.sv =====
module gcn_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [gcn_pkg::ADDR_W-1:0]  paddr,
    input  logic [gcn_pkg::DATA_W-1:0]  pwdata,
    output logic [gcn_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output logic [gcn_pkg::LEN_W-1:0]   pass_len
);
    import gcn_pkg::*;

    logic [DIM_W-1:0] cols_reg;
    logic [DIM_W-1:0] rows_reg;
    logic [DIM_W-1:0] cols_eff;
    logic [DIM_W-1:0] rows_eff;
    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] len_next;
    logic             wr_en;
    logic             reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign wr_en   = psel && penable && pwrite;

    // zero counts as one, oversize clamps to the maximum
    always_comb
    begin
        if (cols_reg == '0)
            cols_eff = DIM_W'(1);
        else if (cols_reg > DIM_W'(MAX_COLS))
            cols_eff = DIM_W'(MAX_COLS);
        else
            cols_eff = cols_reg;

        if (rows_reg == '0)
            rows_eff = DIM_W'(1);
        else if (rows_reg > DIM_W'(MAX_ROWS))
            rows_eff = DIM_W'(MAX_ROWS);
        else
            rows_eff = rows_reg;

        len_next = LEN_W'({{(LEN_W-DIM_W){1'b0}}, cols_eff} *
                          {{(LEN_W-DIM_W){1'b0}}, rows_eff});
    end

    always_comb
    begin
        case (reg_sel)
            REG_COLS: prdata = {{(DATA_W-DIM_W){1'b0}}, cols_reg};
            REG_ROWS: prdata = {{(DATA_W-DIM_W){1'b0}}, rows_reg};
            default:  prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg <= COLS_RESET;
            rows_reg <= ROWS_RESET;
            len_reg  <= LEN_W'(COLS_RESET) * LEN_W'(ROWS_RESET);
        end
        else
        begin
            if (wr_en && reg_sel == REG_COLS)
                cols_reg <= pwdata[DIM_W-1:0];
            if (wr_en && reg_sel == REG_ROWS)
                rows_reg <= pwdata[DIM_W-1:0];
            len_reg <= len_next;
        end
    end

    assign pass_len = len_reg;

endmodule

// ===== hw/rtl/gcn_divider.sv =====
module gcn_divider (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  gcn_pkg::div_req_t          req,
    output logic                       busy,
    output logic                       done,
    output logic [gcn_pkg::PIX_W-1:0]  quot
);
    import gcn_pkg::*;

    typedef enum logic {
        D_IDLE,
        D_RUN
    } div_state_t;

    div_state_t        state_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [PIX_W-1:0]  low_reg;
    logic [PIX_W-1:0]  quot_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [STEP_W-1:0] step_reg;
    logic              done_reg;
    logic [DEN_W:0]    trial;
    logic              fits;

    // one restoring step: shift in the next numerator bit, subtract if it fits
    assign trial = {rem_reg, low_reg[PIX_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            rem_reg   <= '0;
            low_reg   <= '0;
            quot_reg  <= '0;
            den_reg   <= '0;
            step_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                D_IDLE:
                begin
                    if (start)
                    begin
                        // quotient fits in a pixel, so the top bits start below den
                        rem_reg   <= req.num[NUM_W-1:PIX_W];
                        low_reg   <= req.num[PIX_W-1:0];
                        den_reg   <= req.den;
                        quot_reg  <= '0;
                        step_reg  <= '0;
                        state_reg <= D_RUN;
                    end
                end
                D_RUN:
                begin
                    if (fits)
                        rem_reg <= DEN_W'(trial - {1'b0, den_reg});
                    else
                        rem_reg <= trial[DEN_W-1:0];
                    quot_reg <= {quot_reg[PIX_W-2:0], fits};
                    low_reg  <= {low_reg[PIX_W-2:0], 1'b0};
                    step_reg <= step_reg + STEP_W'(1);
                    if (step_reg == STEP_W'(DIV_STEPS - 1))
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= D_IDLE;
                    end
                end
                default:
                    state_reg <= D_IDLE;
            endcase
        end
    end

    assign busy = (state_reg == D_RUN);
    assign done = done_reg;
    assign quot = quot_reg;

endmodule

// ===== hw/rtl/grey_contrast_normalize.sv =====
// Min-max contrast stretch of an 8-bit grey image sent twice in raster order.
// The first image_cols*image_rows pixels are scanned for the darkest and
// lightest value and produce no output; the next equal run produces one
// stretched pixel each, round((p-min)*255/(max-min)) rounded half up, with
// pixels at or beyond the extremes mapped to 0 or 255 and a flat image passed
// unchanged; last_pixel marks the end of the output run, after which the block
// scans again. A dimension of 0 counts as 1 and values above 1024 count as
// 1024. An output pixel that needs a division goes through the 8-step
// restoring divider, which produces one quotient bit per cycle. The input is
// accepted while a finished result is still waiting in the output register.
// Configuration must be written by the user through the APB port only while
// no pixel is in flight; the block itself does not enforce this.
`include "grey_contrast_normalize_assert.svh"

module grey_contrast_normalize (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [gcn_pkg::ADDR_W-1:0]  paddr,
    input  logic [gcn_pkg::DATA_W-1:0]  pwdata,
    output logic [gcn_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    gcn_pix_if.sink                     pix,
    gcn_res_if.source                   res
);
    import gcn_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_EVAL,
        S_DIV,
        S_DONE
    } state_t;

    state_t           state_reg,  state_next;
    logic [PIX_W-1:0] pix_reg,    pix_next;
    logic             pass_reg,   pass_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic [PIX_W-1:0] dark_reg,   dark_next;
    logic [PIX_W-1:0] light_reg,  light_next;
    logic             last_reg,   last_next;
    logic [PIX_W-1:0] result_reg, result_next;
    logic [PIX_W-1:0] span_reg,   span_next;
    logic [PIX_W-1:0] offs_reg,   offs_next;
    logic             ovalid_reg, ovalid_next;
    logic [PIX_W-1:0] opix_reg,   opix_next;
    logic             olast_reg,  olast_next;

    logic [LEN_W-1:0] pass_len;
    logic             last_now;
    logic             div_start;
    div_req_t         div_req;
    logic             div_busy;
    logic             div_done;
    logic [PIX_W-1:0] div_quot;
    logic             load_out;

    gcn_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .pass_len (pass_len)
    );

    gcn_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .req   (div_req),
        .busy  (div_busy),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign pix.ready     = (state_reg == S_IDLE);
    assign res.valid     = ovalid_reg;
    assign res.pixel_out = opix_reg;
    assign res.last_pixel = olast_reg;

    assign last_now = ({1'b0, count_reg} + (CNT_W+1)'(1)) >= {1'b0, pass_len};
    assign load_out = (state_reg == S_DONE) && (!ovalid_reg || res.ready);

    // numerator (p-min)*510 + (max-min), denominator 2*(max-min)
    assign div_req.num = NUM_W'({offs_reg, 9'b0}) - NUM_W'({offs_reg, 1'b0})
                       + NUM_W'(span_reg);
    assign div_req.den = {span_reg, 1'b0};

    always_comb
    begin
        state_next  = state_reg;
        pix_next    = pix_reg;
        pass_next   = pass_reg;
        count_next  = count_reg;
        dark_next   = dark_reg;
        light_next  = light_reg;
        last_next   = last_reg;
        result_next = result_reg;
        span_next   = span_reg;
        offs_next   = offs_reg;
        opix_next   = opix_reg;
        olast_next  = olast_reg;
        ovalid_next = ovalid_reg;
        div_start   = 1'b0;

        if (ovalid_reg && res.ready)
            ovalid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (pix.valid)
                begin
                    pix_next   = pix.pixel_in;
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                span_next  = light_reg - dark_reg;
                offs_next  = pix_reg - dark_reg;
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (!pass_reg)
                begin
                    if (pix_reg < dark_reg)
                        dark_next = pix_reg;
                    if (pix_reg > light_reg)
                        light_next = pix_reg;
                    if (last_now)
                    begin
                        pass_next  = 1'b1;
                        count_next = '0;
                    end
                    else
                        count_next = count_reg + CNT_W'(1);
                    state_next = S_IDLE;
                end
                else
                begin
                    last_next = last_now;
                    if (light_reg <= dark_reg)
                    begin
                        result_next = pix_reg;
                        state_next  = S_DONE;
                    end
                    else if (pix_reg >= light_reg)
                    begin
                        result_next = PIX_MAX;
                        state_next  = S_DONE;
                    end
                    else if (pix_reg <= dark_reg)
                    begin
                        result_next = PIX_MIN;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    result_next = div_quot;
                    state_next  = S_DONE;
                end
            end
            S_DONE:
            begin
                if (load_out)
                begin
                    ovalid_next = 1'b1;
                    opix_next   = result_reg;
                    olast_next  = last_reg;
                    if (last_reg)
                    begin
                        pass_next  = 1'b0;
                        count_next = '0;
                        dark_next  = PIX_MAX;
                        light_next = PIX_MIN;
                    end
                    else
                        count_next = count_reg + CNT_W'(1);
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            pix_reg    <= '0;
            pass_reg   <= 1'b0;
            count_reg  <= '0;
            dark_reg   <= PIX_MAX;
            light_reg  <= PIX_MIN;
            last_reg   <= 1'b0;
            result_reg <= '0;
            span_reg   <= '0;
            offs_reg   <= '0;
            ovalid_reg <= 1'b0;
            opix_reg   <= '0;
            olast_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            pix_reg    <= pix_next;
            pass_reg   <= pass_next;
            count_reg  <= count_next;
            dark_reg   <= dark_next;
            light_reg  <= light_next;
            last_reg   <= last_next;
            result_reg <= result_next;
            span_reg   <= span_next;
            offs_reg   <= offs_next;
            ovalid_reg <= ovalid_next;
            opix_reg   <= opix_next;
            olast_reg  <= olast_next;
        end
    end

    // the divider is never running while a new pixel can be taken
    `GCN_ASSERT_SAME(a_ready_div_idle, clk, rst_n, pix.ready, !div_busy)
    // leaving the output pass always goes with the marked final pixel
    `GCN_ASSERT_SAME(a_pass_end_last, clk, rst_n, $fell(pass_reg), res.valid && res.last_pixel)
    // once a pixel has been scanned the extremes are ordered
    `GCN_ASSERT_SAME(a_extremes_order, clk, rst_n, pass_reg || count_reg != '0, dark_reg <= light_reg)
    // a division is started only for a pixel of the output pass
    `GCN_ASSERT_NEXT(a_div_output_only, clk, rst_n, div_start, div_busy && pass_reg)

endmodule
